[rtl/core/ebr_pkg.sv]
// Shared constants and types of the embedding-bag reduction engine.
`default_nettype none
package ebr_pkg;

    localparam int TABLE_ROWS = 4096;
    localparam int ROW_W      = $clog2(TABLE_ROWS);
    localparam int MAX_DIM    = 64;
    localparam int COL_W      = 6;
    localparam int DIM_W      = 7;
    localparam int MAX_BAG    = 64;
    localparam int LEN_W      = $clog2(MAX_BAG + 1);
    localparam int POS_SLOTS  = 64;
    localparam int SLOT_W     = $clog2(POS_SLOTS);
    localparam int ACC_W      = 48;
    localparam int ONE_Q412   = 4096;

    localparam logic [2:0] OP_WR_ELEM   = 3'd0;
    localparam logic [2:0] OP_WR_SB     = 3'd1;
    localparam logic [2:0] OP_WR_POS    = 3'd2;
    localparam logic [2:0] OP_LOOKUP    = 3'd3;
    localparam logic [2:0] OP_EMPTY_BAG = 3'd4;

    localparam logic [2:0] CFG_DIM     = 3'd0;
    localparam logic [2:0] CFG_ROWS    = 3'd1;
    localparam logic [2:0] CFG_NORM    = 3'd2;
    localparam logic [2:0] CFG_WMODE   = 3'd3;
    localparam logic [2:0] CFG_QUANT   = 3'd4;

    localparam logic [1:0] WMODE_ITEM = 2'd1;
    localparam logic [1:0] WMODE_POS  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

[rtl/core/embedding_bag_reduce_top.sv]
// Top level of the embedding-bag reduction engine.
// Items arrive on the in_valid/in_ready channel; one beat carries one item.
// Write items (element, scale and bias, positional weight) go straight to their memories.
// A lookup reads one table row and accumulates it column by column in an
// accumulator memory through a three-stage read-modify-write pipeline.
// When a bag closes, one result beat per used column leaves on the
// out_valid/out_ready channel through an output register. In mean mode
// each column of a non-empty bag passes through the iterative divider, which
// produces one quotient bit per cycle. The next item is taken once the last
// result of the bag sits in the output register.
// If the receiver stalls, the engine holds the next result until the output
// register is free; nothing is lost. Configuration writes are taken at any
// time on cfg_valid/cfg_ready and must only be issued while the engine is idle.
// Reset clears the configuration to its defaults, empties the bag and marks
// every accumulator as zero; table contents are undefined until written.
`default_nettype none
module embedding_bag_reduce_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  op,
    input  wire logic signed [31:0] row_index,
    input  wire logic [5:0]  column,
    input  wire logic signed [15:0] value_a,
    input  wire logic signed [15:0] value_b,
    input  wire logic signed [15:0] weight,
    input  wire logic        last_in_bag,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] result_value,
    output logic [5:0]       result_column,
    output logic             last_of_vector,
    output logic             bag_error
);

    localparam int ROW_W = ebr_pkg::ROW_W;
    localparam int COL_W = ebr_pkg::COL_W;
    localparam int ACC_W = ebr_pkg::ACC_W;
    localparam int LEN_W = ebr_pkg::LEN_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SETUP   = 9'b000000010,
        S_WGT     = 9'b000000100,
        S_RUN     = 9'b000001000,
        S_DRAIN   = 9'b000010000,
        S_CL_RD   = 9'b000100000,
        S_CL_DATA = 9'b001000000,
        S_CL_DIV  = 9'b010000000,
        S_CL_OUT  = 9'b100000000
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W:0] v);
        logic hi_same;
        hi_same = (&v[ACC_W:31]) || !(|v[ACC_W:31]);
        if (hi_same)
            return v[31:0];
        return v[ACC_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [ebr_pkg::DIM_W-1:0] dim_reg;
    logic [12:0]               rows_reg;
    logic                      norm_reg;
    logic [1:0]                wmode_reg;
    logic                      quant_reg;

    logic [ROW_W-1:0]   row_reg;
    logic signed [15:0] item_w_reg;
    logic               last_reg;
    logic [COL_W-1:0]   j_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               err_reg;
    logic [ebr_pkg::MAX_DIM-1:0] acc_vld_reg;

    logic signed [15:0] w_reg;
    logic signed [31:0] ws_reg;
    logic signed [31:0] wb_reg;

    logic               v1_reg;
    logic [COL_W-1:0]   c1_reg;
    logic               v2_reg;
    logic [COL_W-1:0]   c2_reg;
    logic signed [40:0] p2_reg;
    logic signed [ACC_W-1:0] a2_reg;

    logic               neg_reg;
    logic signed [31:0] res_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic               out_last_reg;
    logic               out_err_reg;

    logic [ebr_pkg::DIM_W-1:0] dims;
    logic                      last_col;
    logic [12:0]               limit;
    logic                      accept;
    logic                      wr_row_ok;
    logic                      lk_bad;
    logic                      bag_full;
    logic [ebr_pkg::SLOT_W-1:0] slot;

    logic [15:0]              tbl_rdata;
    logic [31:0]              sb_rdata;
    logic [15:0]              pw_rdata;
    logic [ACC_W-1:0]         acc_rdata;
    logic                     acc_we;
    logic [ACC_W-1:0]         acc_wdata;

    logic signed [15:0] w_sel;
    logic signed [15:0] elem;
    logic signed [40:0] prod_q;
    logic signed [31:0] prod_n;
    logic signed [41:0] sum3;
    logic signed [41:0] rnd3;
    logic signed [ACC_W:0] acc_sum;

    logic signed [ACC_W-1:0] a_cl;
    logic [ACC_W-1:0]        mag_cl;
    logic                    do_div;
    logic signed [ACC_W:0]   q_signed;
    logic                    out_free;

    ebr_pkg::div_req_t div_req;
    ebr_pkg::div_rsp_t div_rsp;

    assign dims = (dim_reg == '0) ? ebr_pkg::DIM_W'(1) :
                  (dim_reg > ebr_pkg::DIM_W'(ebr_pkg::MAX_DIM)) ?
                  ebr_pkg::DIM_W'(ebr_pkg::MAX_DIM) : dim_reg;
    assign last_col = ({1'b0, j_reg} == dims - 1'b1);
    assign limit = (rows_reg < 13'(ebr_pkg::TABLE_ROWS)) ? rows_reg : 13'(ebr_pkg::TABLE_ROWS);
    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign wr_row_ok = !row_index[31] && (row_index[30:0] < 31'(ebr_pkg::TABLE_ROWS));
    assign lk_bad = row_index[31] || (row_index[30:0] >= 31'(limit));
    assign bag_full = (len_reg >= LEN_W'(ebr_pkg::MAX_BAG));
    assign slot = (len_reg >= LEN_W'(ebr_pkg::POS_SLOTS)) ?
                  ebr_pkg::SLOT_W'(ebr_pkg::POS_SLOTS - 1) : len_reg[ebr_pkg::SLOT_W-1:0];
    assign out_free = !out_valid_reg || out_ready;

    ebr_ram #(.WIDTH(16), .DEPTH(ebr_pkg::TABLE_ROWS * ebr_pkg::MAX_DIM)) u_table (
        .clk   (clk),
        .we    (accept && op == ebr_pkg::OP_WR_ELEM && wr_row_ok),
        .waddr ({row_index[ROW_W-1:0], column}),
        .wdata (value_a),
        .raddr ({row_reg, j_reg}),
        .rdata (tbl_rdata)
    );

    ebr_ram #(.WIDTH(32), .DEPTH(ebr_pkg::TABLE_ROWS)) u_scale_bias (
        .clk   (clk),
        .we    (accept && op == ebr_pkg::OP_WR_SB && wr_row_ok),
        .waddr (row_index[ROW_W-1:0]),
        .wdata ({value_b, value_a}),
        .raddr (row_reg),
        .rdata (sb_rdata)
    );

    ebr_ram #(.WIDTH(16), .DEPTH(ebr_pkg::POS_SLOTS)) u_pos_weight (
        .clk   (clk),
        .we    (accept && op == ebr_pkg::OP_WR_POS),
        .waddr (column[ebr_pkg::SLOT_W-1:0]),
        .wdata (value_a),
        .raddr (slot),
        .rdata (pw_rdata)
    );

    ebr_ram #(.WIDTH(ACC_W), .DEPTH(ebr_pkg::MAX_DIM)) u_acc (
        .clk   (clk),
        .we    (acc_we),
        .waddr (c2_reg),
        .wdata (acc_wdata),
        .raddr (j_reg),
        .rdata (acc_rdata)
    );

    ebr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Weight selection and the multiply-accumulate pipeline.
    always_comb
    begin
        if (wmode_reg == ebr_pkg::WMODE_ITEM)
            w_sel = item_w_reg;
        else if (wmode_reg == ebr_pkg::WMODE_POS)
            w_sel = pw_rdata;
        else
            w_sel = 16'(ebr_pkg::ONE_Q412);
    end

    assign elem    = tbl_rdata;
    assign prod_q  = ws_reg * $signed({1'b0, elem[7:0]});
    assign prod_n  = w_reg * elem;
    assign sum3    = p2_reg + (quant_reg ? wb_reg : 32'sd0);
    assign rnd3    = (sum3 + 42'sd8) >>> 4;
    assign acc_sum = a2_reg + rnd3;
    assign acc_we  = v2_reg;
    assign acc_wdata = (acc_sum[ACC_W] != acc_sum[ACC_W-1]) ?
                       (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
                       acc_sum[ACC_W-1:0];

    // Close path: sign, magnitude and rounding offset for the mean.
    assign a_cl    = acc_vld_reg[j_reg] ? acc_rdata : '0;
    assign mag_cl  = a_cl[ACC_W-1] ? ACC_W'(-a_cl) : a_cl;
    assign do_div  = norm_reg && (len_reg != '0);
    assign div_req.start    = (state_reg == S_CL_DATA) && do_div;
    assign div_req.dividend = mag_cl + ACC_W'(len_reg >> 1);
    assign div_req.divisor  = len_reg;
    assign q_signed = neg_reg ? -$signed({1'b0, div_rsp.quotient}) :
                      $signed({1'b0, div_rsp.quotient});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == ebr_pkg::OP_EMPTY_BAG)
                    state_next = S_CL_RD;
                else if (accept && op == ebr_pkg::OP_LOOKUP)
                begin
                    if (bag_full || lk_bad)
                        state_next = last_in_bag ? S_CL_RD : S_IDLE;
                    else
                        state_next = S_SETUP;
                end
            end
            S_SETUP:   state_next = S_WGT;
            S_WGT:     state_next = S_RUN;
            S_RUN:     state_next = last_col ? S_DRAIN : S_RUN;
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = last_reg ? S_CL_RD : S_IDLE;
            end
            S_CL_RD:   state_next = S_CL_DATA;
            S_CL_DATA: state_next = do_div ? S_CL_DIV : S_CL_OUT;
            S_CL_DIV:  state_next = div_rsp.done ? S_CL_OUT : S_CL_DIV;
            S_CL_OUT:
            begin
                if (out_free)
                    state_next = last_col ? S_IDLE : S_CL_RD;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dim_reg       <= ebr_pkg::DIM_W'(64);
            rows_reg      <= 13'd4096;
            norm_reg      <= 1'b0;
            wmode_reg     <= 2'd0;
            quant_reg     <= 1'b0;
            j_reg         <= '0;
            len_reg       <= '0;
            err_reg       <= 1'b0;
            acc_vld_reg   <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ebr_pkg::CFG_DIM:   dim_reg   <= cfg_data[ebr_pkg::DIM_W-1:0];
                    ebr_pkg::CFG_ROWS:  rows_reg  <= cfg_data[12:0];
                    ebr_pkg::CFG_NORM:  norm_reg  <= cfg_data[0];
                    ebr_pkg::CFG_WMODE: wmode_reg <= cfg_data[1:0];
                    ebr_pkg::CFG_QUANT: quant_reg <= cfg_data[0];
                    default:            ;
                endcase
            end

            v1_reg <= (state_reg == S_RUN);
            v2_reg <= v1_reg;
            if (v2_reg)
                acc_vld_reg[c2_reg] <= 1'b1;

            if (state_reg == S_IDLE && accept)
            begin
                j_reg <= '0;
                if (op == ebr_pkg::OP_LOOKUP)
                begin
                    if (bag_full)
                        err_reg <= 1'b1;
                    else if (lk_bad)
                    begin
                        err_reg <= 1'b1;
                        len_reg <= len_reg + 1'b1;
                    end
                end
            end
            else if (state_reg == S_WGT)
                j_reg <= '0;
            else if (state_reg == S_RUN && !last_col)
                j_reg <= j_reg + 1'b1;
            else if (state_reg == S_DRAIN && !v1_reg && !v2_reg)
            begin
                len_reg <= len_reg + 1'b1;
                j_reg   <= '0;
            end
            else if (state_reg == S_CL_OUT && out_free)
            begin
                if (last_col)
                begin
                    acc_vld_reg <= '0;
                    len_reg     <= '0;
                    err_reg     <= 1'b0;
                end
                else
                    j_reg <= j_reg + 1'b1;
            end

            if (state_reg == S_CL_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg    <= row_index[ROW_W-1:0];
            item_w_reg <= weight;
            last_reg   <= last_in_bag;
        end
        if (state_reg == S_WGT)
        begin
            w_reg  <= w_sel;
            ws_reg <= w_sel * $signed(sb_rdata[15:0]);
            wb_reg <= w_sel * $signed(sb_rdata[31:16]);
        end
        c1_reg <= j_reg;
        c2_reg <= c1_reg;
        p2_reg <= quant_reg ? prod_q : 41'(prod_n);
        a2_reg <= acc_vld_reg[c1_reg] ? acc_rdata : '0;
        if (state_reg == S_CL_DATA)
        begin
            neg_reg <= a_cl[ACC_W-1];
            res_reg <= sat32((ACC_W+1)'(a_cl));
        end
        else if (state_reg == S_CL_DIV && div_rsp.done)
            res_reg <= sat32(q_signed);
        if (state_reg == S_CL_OUT && out_free)
        begin
            out_value_reg <= res_reg;
            out_col_reg   <= j_reg;
            out_last_reg  <= last_col;
            out_err_reg   <= err_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = out_value_reg;
    assign result_column  = out_col_reg;
    assign last_of_vector = out_last_reg;
    assign bag_error      = out_err_reg;

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!v1_reg && !v2_reg))
        else $error("Accumulate pipeline busy while taking a new item.");

    a_div_only_closing: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> (state_reg == S_CL_DIV))
        else $error("Divider busy outside the mean step.");

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(ebr_pkg::MAX_BAG))
        else $error("Bag length beyond its limit.");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CL_OUT && out_free) |=> out_valid_reg)
        else $error("Result beat lost on load.");
`endif

endmodule
`default_nettype wire

[rtl/core/ebr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ebr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/core/ebr_div.sv]
// Restoring divider, one quotient bit per cycle, for the bag mean.
`default_nettype none
module ebr_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ebr_pkg::div_req_t req,
    output ebr_pkg::div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(ebr_pkg::ACC_W);

    logic [ebr_pkg::ACC_W-1:0] dvd_reg;
    logic [ebr_pkg::LEN_W-1:0] div_reg;
    logic [ebr_pkg::LEN_W-1:0] rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [ebr_pkg::LEN_W:0]   trial;
    logic                      qbit;
    logic [ebr_pkg::LEN_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[ebr_pkg::ACC_W-1]};
    assign qbit  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ebr_pkg::ACC_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ebr_pkg::ACC_W-2:0], qbit};
            rem_reg <= qbit ? diff[ebr_pkg::LEN_W-1:0] : trial[ebr_pkg::LEN_W-1:0];
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule
`default_nettype wire
